// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker module of this block.
// Depends on nothing; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Antecedent implies consequent in the next cycle.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Plain implication with no reset disable, for checks across reset.
`define CHK_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("check failed");

`endif

// ----- rtl/i2cseq_pkg.sv -----
// Package for the I2C master transfer sequencer: word types and status codes.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package i2cseq_pkg;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_EVENT = 1'b1;

   localparam logic [7:0] ST_IDLE      = 8'hF8;
   localparam logic [7:0] ST_START     = 8'h08;
   localparam logic [7:0] ST_RSTART    = 8'h10;
   localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
   localparam logic [7:0] ST_DATW_ACK  = 8'h28;
   localparam logic [7:0] ST_DATR_ACK  = 8'h50;
   localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
   localparam logic [7:0] ST_DATR_NACK = 8'h58;
   localparam logic [7:0] ST_SLAW_NACK = 8'h20;
   localparam logic [7:0] ST_DATW_NACK = 8'h30;
   localparam logic [7:0] ST_SLAR_NACK = 8'h48;
   localparam logic [7:0] ST_ARB_LOST  = 8'h38;

   typedef struct packed {
      logic       func;
      logic [7:0] slave_addr;
      logic [7:0] tx_count;
      logic [7:0] rx_count;
      logic [7:0] status_code;
      logic [7:0] rx_byte;
      logic [7:0] tx_byte;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic       busy_now;
      logic       dat_write;
      logic [7:0] dat_value;
      logic       start_set;
      logic       start_clear;
      logic       stop_set;
      logic       ack_set;
      logic       ack_clear;
      logic       tx_pop;
      logic       rx_valid;
      logic [7:0] rx_data;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/i2cseq_decode.sv -----
// Combinational decode of one word: start request or bus status event.
// Depends on i2cseq_pkg; gives the result word and the next sequencer state.
`default_nettype none

module i2cseq_decode #(
   parameter int COUNT_WIDTH = 8
) (
   input  i2cseq_pkg::req_type  item,
   input  logic                 busy_cur,
   input  logic [7:0]           addr_cur,
   input  logic [COUNT_WIDTH-1:0] tx_cur,
   input  logic [COUNT_WIDTH-1:0] rx_cur,
   input  logic [7:0]           status_cur,
   output logic                 busy_nxt,
   output logic [7:0]           addr_nxt,
   output logic [COUNT_WIDTH-1:0] tx_nxt,
   output logic [COUNT_WIDTH-1:0] rx_nxt,
   output logic [7:0]           status_nxt,
   output i2cseq_pkg::rsp_type  result
);
   import i2cseq_pkg::*;

   localparam int CmpW = COUNT_WIDTH + 8;
   localparam logic [CmpW-1:0] CountMax = {{8{1'b0}}, {COUNT_WIDTH{1'b1}}};
   localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);

   logic [CmpW-1:0]        tc_ext;
   logic [CmpW-1:0]        rc_ext;
   logic [COUNT_WIDTH-1:0] tc_sat;
   logic [COUNT_WIDTH-1:0] rc_sat;
   logic [COUNT_WIDTH-1:0] tx_dec;
   logic [COUNT_WIDTH-1:0] rx_dec;
   logic                   busy_before;

   assign tc_ext = CmpW'(item.tx_count);
   assign rc_ext = CmpW'(item.rx_count);
   assign tc_sat = (tc_ext > CountMax) ? {COUNT_WIDTH{1'b1}} : tc_ext[COUNT_WIDTH-1:0];
   assign rc_sat = (rc_ext > CountMax) ? {COUNT_WIDTH{1'b1}} : rc_ext[COUNT_WIDTH-1:0];
   assign tx_dec = (tx_cur == '0) ? '0 : tx_cur - CountOne;
   assign rx_dec = (rx_cur == '0) ? '0 : rx_cur - CountOne;
   assign busy_before = busy_cur | (status_cur != ST_IDLE);

   always_comb begin
      result     = '0;
      busy_nxt   = busy_cur;
      addr_nxt   = addr_cur;
      tx_nxt     = tx_cur;
      rx_nxt     = rx_cur;
      status_nxt = status_cur;
      if (item.func == FUNC_START) begin
         if (!busy_before) begin
            result.accepted = 1'b1;
            if ((tc_sat != '0) || (rc_sat != '0)) begin
               addr_nxt         = {item.slave_addr[7:1], 1'b0};
               tx_nxt           = tc_sat;
               rx_nxt           = rc_sat;
               result.start_set = 1'b1;
               busy_nxt         = 1'b1;
            end
         end
      end else begin
         status_nxt = item.status_code;
         unique case (item.status_code)
            ST_START, ST_RSTART: begin
               result.dat_write   = 1'b1;
               result.dat_value   = {addr_cur[7:1], addr_cur[0] | (tx_cur == '0)};
               result.start_clear = 1'b1;
               result.ack_set     = 1'b1;
            end
            ST_SLAW_ACK, ST_DATW_ACK: begin
               result.ack_set = 1'b1;
               if (tx_cur != '0) begin
                  result.dat_write = 1'b1;
                  result.dat_value = item.tx_byte;
                  result.tx_pop    = 1'b1;
                  tx_nxt           = tx_dec;
               end else if (rx_cur != '0) begin
                  result.start_set = 1'b1;
               end else begin
                  result.stop_set = 1'b1;
                  busy_nxt        = 1'b0;
               end
            end
            ST_DATR_ACK: begin
               result.rx_valid  = 1'b1;
               result.rx_data   = item.rx_byte;
               rx_nxt           = rx_dec;
               result.ack_clear = (rx_dec == CountOne);
               result.ack_set   = (rx_dec != CountOne);
            end
            ST_SLAR_ACK: begin
               result.ack_clear = (rx_cur == CountOne);
               result.ack_set   = (rx_cur != CountOne);
            end
            ST_DATR_NACK: begin
               result.rx_valid = 1'b1;
               result.rx_data  = item.rx_byte;
               rx_nxt          = rx_dec;
               result.ack_set  = 1'b1;
               result.stop_set = 1'b1;
               busy_nxt        = 1'b0;
            end
            ST_SLAW_NACK, ST_DATW_NACK, ST_SLAR_NACK: begin
               result.ack_set  = 1'b1;
               result.stop_set = 1'b1;
               busy_nxt        = 1'b0;
            end
            ST_ARB_LOST: begin
               result.ack_clear   = 1'b1;
               result.start_clear = 1'b1;
               busy_nxt           = 1'b0;
            end
            default: begin
            end
         endcase
      end
      result.busy_now = busy_nxt | (status_nxt != ST_IDLE);
   end

endmodule

`default_nettype wire

// ----- rtl/i2c_master_transfer_sequencer_core.sv -----
// A word taken into the input register is decoded into the result register.
// Throughput: one word per cycle while the result is not stalled; the input
// register and the result register each hold one word, and the sequencer state
// updates as a word moves between them. Reset empties both word registers and
// sets the state to idle (status 0xF8). Depends on i2cseq_pkg and i2cseq_decode.
`default_nettype none

module i2c_master_transfer_sequencer_core #(
   parameter int COUNT_WIDTH = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  i2cseq_pkg::req_type req,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output i2cseq_pkg::rsp_type rsp
);
   import i2cseq_pkg::*;

   logic                   req_valid_ff;
   logic                   req_valid_in;
   req_type                req_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   logic                   busy_ff;
   logic                   busy_in;
   logic [7:0]             addr_ff;
   logic [7:0]             addr_in;
   logic [COUNT_WIDTH-1:0] tx_left_ff;
   logic [COUNT_WIDTH-1:0] tx_left_in;
   logic [COUNT_WIDTH-1:0] rx_left_ff;
   logic [COUNT_WIDTH-1:0] rx_left_in;
   logic [7:0]             status_ff;
   logic [7:0]             status_in;
   logic                   load;
   logic                   advance;

   assign advance      = req_valid_ff & ~(rsp_valid_ff & rsp_stall);
   assign req_stall    = req_valid_ff & ~advance;
   assign load         = req_valid & ~req_stall;
   assign req_valid_in = load | (req_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   i2cseq_decode #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_decode (
      .item       (req_ff),
      .busy_cur   (busy_ff),
      .addr_cur   (addr_ff),
      .tx_cur     (tx_left_ff),
      .rx_cur     (rx_left_ff),
      .status_cur (status_ff),
      .busy_nxt   (busy_in),
      .addr_nxt   (addr_in),
      .tx_nxt     (tx_left_in),
      .rx_nxt     (rx_left_in),
      .status_nxt (status_in),
      .result     (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
         addr_ff      <= '0;
         tx_left_ff   <= '0;
         rx_left_ff   <= '0;
         status_ff    <= ST_IDLE;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            busy_ff    <= busy_in;
            addr_ff    <= addr_in;
            tx_left_ff <= tx_left_in;
            rx_left_ff <= rx_left_in;
            status_ff  <= status_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         req_ff <= req;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/i2cseq_checker.sv -----
// Port-level checks for the I2C master transfer sequencer, bound to the top level.
// Depends on i2cseq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module i2cseq_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire i2cseq_pkg::req_type req,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire i2cseq_pkg::rsp_type rsp
);
   import i2cseq_pkg::*;

   logic word_in;

   assign word_in = req_valid & ~req_stall & (req.func == FUNC_START | req.func == FUNC_EVENT);

   // A stalled result word stays in place.
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
   // An accepted start never carries data register or receive actions.
   `CHK_IMPLY(a_accept_excl, clock, reset, rsp_valid && rsp.accepted, !rsp.dat_write && !rsp.rx_valid && !rsp.stop_set)
   // A start that asks for START leaves the sequencer busy.
   `CHK_IMPLY(a_start_busy, clock, reset, rsp_valid && rsp.accepted && rsp.start_set, rsp.busy_now)
   // Nothing comes out in the cycle after reset.
   `CHK_ALWAYS(a_reset_empty, clock, $past(reset) && !reset, !rsp_valid)
   // A word taken on an idle pipeline surfaces once it has passed the input and result registers.
   `CHK_IMPLY(a_latency, clock, reset, $past(word_in, 2) && !$past(rsp_valid, 2) && !$past(req_stall, 1) && !$past(reset, 2), rsp_valid)

endmodule

bind i2c_master_transfer_sequencer_core i2cseq_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for i2c_master_transfer_sequencer_core: it drives start requests and
// bus status words, predicts every controller action word and checks it field by field.
// Depends on i2cseq_pkg and the core's RTL.

module testbench;
   import i2cseq_pkg::*;

   localparam int COUNT_WIDTH = 8;
   localparam int COUNT_MAX = (1 << COUNT_WIDTH) - 1;
   localparam int ITEM_TARGET = 1350;
   localparam int STALL_LIMIT = 1000;

   class action_book;
      logic                   busy_flag;
      logic [7:0]             target_addr;
      logic [COUNT_WIDTH-1:0] tx_left;
      logic [COUNT_WIDTH-1:0] rx_left;
      logic [7:0]             last_status;
      rsp_type                pending[$];
      int                     mismatches;

      function new();
         busy_flag = 1'b0;
         target_addr = '0;
         tx_left = '0;
         rx_left = '0;
         last_status = ST_IDLE;
         mismatches = 0;
      endfunction

      function void note_request(req_type w);
         rsp_type r;
         r = '0;
         if (w.func == FUNC_START) begin
            if (!busy_flag && last_status == ST_IDLE) begin
               r.accepted = 1'b1;
               if (w.tx_count != 0 || w.rx_count != 0) begin
                  target_addr = {w.slave_addr[7:1], 1'b0};
                  tx_left = (w.tx_count > COUNT_MAX) ? COUNT_WIDTH'(COUNT_MAX)
                                                     : COUNT_WIDTH'(w.tx_count);
                  rx_left = (w.rx_count > COUNT_MAX) ? COUNT_WIDTH'(COUNT_MAX)
                                                     : COUNT_WIDTH'(w.rx_count);
                  r.start_set = 1'b1;
                  busy_flag = 1'b1;
               end
            end
         end else begin
            last_status = w.status_code;
            case (w.status_code)
               ST_START, ST_RSTART: begin
                  r.dat_write = 1'b1;
                  r.dat_value = (tx_left != 0) ? target_addr : (target_addr | 8'h01);
                  r.start_clear = 1'b1;
                  r.ack_set = 1'b1;
               end
               ST_SLAW_ACK, ST_DATW_ACK: begin
                  r.ack_set = 1'b1;
                  if (tx_left != 0) begin
                     r.dat_write = 1'b1;
                     r.dat_value = w.tx_byte;
                     r.tx_pop = 1'b1;
                     tx_left = tx_left - 1'b1;
                  end else if (rx_left != 0) begin
                     r.start_set = 1'b1;
                  end else begin
                     r.stop_set = 1'b1;
                     busy_flag = 1'b0;
                  end
               end
               ST_DATR_ACK, ST_SLAR_ACK: begin
                  if (w.status_code == ST_DATR_ACK) begin
                     r.rx_valid = 1'b1;
                     r.rx_data = w.rx_byte;
                     if (rx_left != 0) rx_left = rx_left - 1'b1;
                  end
                  if (rx_left == 1) r.ack_clear = 1'b1;
                  else r.ack_set = 1'b1;
               end
               ST_DATR_NACK, ST_SLAW_NACK, ST_DATW_NACK, ST_SLAR_NACK: begin
                  if (w.status_code == ST_DATR_NACK) begin
                     r.rx_valid = 1'b1;
                     r.rx_data = w.rx_byte;
                     if (rx_left != 0) rx_left = rx_left - 1'b1;
                  end
                  r.ack_set = 1'b1;
                  r.stop_set = 1'b1;
                  busy_flag = 1'b0;
               end
               ST_ARB_LOST: begin
                  r.ack_clear = 1'b1;
                  r.start_clear = 1'b1;
                  busy_flag = 1'b0;
               end
               default: begin
               end
            endcase
         end
         r.busy_now = busy_flag || (last_status != ST_IDLE);
         pending.push_back(r);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_actions(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $error("result word arrived with no request outstanding");
            mismatches++;
            return;
         end
         want = pending.pop_front();
         compare_field("accepted", 8'(want.accepted), 8'(got.accepted));
         compare_field("busy_now", 8'(want.busy_now), 8'(got.busy_now));
         compare_field("dat_write", 8'(want.dat_write), 8'(got.dat_write));
         compare_field("dat_value", want.dat_value, got.dat_value);
         compare_field("start_set", 8'(want.start_set), 8'(got.start_set));
         compare_field("start_clear", 8'(want.start_clear), 8'(got.start_clear));
         compare_field("stop_set", 8'(want.stop_set), 8'(got.stop_set));
         compare_field("ack_set", 8'(want.ack_set), 8'(got.ack_set));
         compare_field("ack_clear", 8'(want.ack_clear), 8'(got.ack_clear));
         compare_field("tx_pop", 8'(want.tx_pop), 8'(got.tx_pop));
         compare_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
         compare_field("rx_data", want.rx_data, got.rx_data);
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   action_book book;
   bit         calm = 1'b0;
   int         items_sent = 0;
   int         idle_cycles = 0;
   int         stall_left = 0;

   i2c_master_transfer_sequencer_core #(.COUNT_WIDTH(COUNT_WIDTH)) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req(req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp(rsp)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (req_valid && !req_stall) begin
            book.note_request(req);
            idle_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            book.check_actions(rsp);
            idle_cycles = 0;
            stall_left = calm ? 0 : $urandom_range(0, 3);
         end else if (rsp_valid && stall_left > 0) begin
            stall_left = stall_left - 1;
         end
      end
      rsp_stall <= (stall_left != 0);
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("i2c_master_transfer_sequencer_core: mismatch");
      $finish;
   end

   function automatic req_type random_word();
      req_type w;
      w.func = 1'($urandom);
      w.slave_addr = 8'($urandom);
      w.tx_count = 8'($urandom);
      w.rx_count = 8'($urandom);
      w.status_code = 8'($urandom);
      w.rx_byte = 8'($urandom);
      w.tx_byte = 8'($urandom);
      return w;
   endfunction

   function automatic logic [7:0] pick_status();
      case ($urandom_range(0, 13))
         0: return ST_IDLE;
         1: return ST_START;
         2: return ST_RSTART;
         3: return ST_SLAW_ACK;
         4: return ST_DATW_ACK;
         5: return ST_DATR_ACK;
         6: return ST_SLAR_ACK;
         7: return ST_DATR_NACK;
         8: return ST_SLAW_NACK;
         9: return ST_DATW_NACK;
         10: return ST_SLAR_NACK;
         11: return ST_ARB_LOST;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] draw_count();
      if ($urandom_range(0, 39) == 0) return 8'($urandom);
      return 8'($urandom_range(0, 4));
   endfunction

   task automatic send_word(input req_type w);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_event(input logic [7:0] code);
      req_type w;
      w = random_word();
      w.func = FUNC_EVENT;
      w.status_code = code;
      send_word(w);
   endtask

   task automatic send_start(input logic [7:0] addr, input logic [7:0] tc,
                             input logic [7:0] rc);
      req_type w;
      w = random_word();
      w.func = FUNC_START;
      w.slave_addr = addr;
      w.tx_count = tc;
      w.rx_count = rc;
      send_word(w);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.pending.size() != 0) @(posedge clock);
   endtask

   task automatic clean_up();
      send_event(ST_ARB_LOST);
      send_event(ST_IDLE);
   endtask

   task automatic stir_noise();
      req_type w;
      int n;
      n = $urandom_range(1, 6);
      repeat (n) begin
         w = random_word();
         if ($urandom_range(0, 1) == 1) w.status_code = pick_status();
         send_word(w);
      end
      clean_up();
   endtask

   task automatic run_transfer();
      logic [7:0] tc;
      logic [7:0] rc;
      logic [7:0] script[$];
      req_type    w;
      tc = draw_count();
      rc = draw_count();
      if (tc != 0 || rc != 0) begin
         script.push_back(ST_START);
         if (tc != 0) begin
            script.push_back(ST_SLAW_ACK);
            repeat (tc) script.push_back(ST_DATW_ACK);
         end
         if (rc != 0) begin
            if (tc != 0) script.push_back(ST_RSTART);
            script.push_back(ST_SLAR_ACK);
            repeat (rc - 1) script.push_back(ST_DATR_ACK);
            script.push_back(ST_DATR_NACK);
         end
      end
      script.push_back(ST_IDLE);
      send_start(8'($urandom), tc, rc);
      foreach (script[i]) begin
         if ($urandom_range(0, 24) == 0) begin
            w = random_word();
            if ($urandom_range(0, 2) != 0) begin
               w.func = FUNC_EVENT;
               w.status_code = pick_status();
            end
            send_word(w);
            if ($urandom_range(0, 3) != 0) clean_up();
            return;
         end
         send_event(script[i]);
      end
   endtask

   initial begin
      book = new;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_event(ST_DATR_ACK);
      send_start(8'hFF, 8'h01, 8'h01);
      send_event(ST_IDLE);
      send_start(8'h00, 8'h00, 8'h00);
      send_start(8'hA5, 8'h01, 8'h02);
      send_start(8'h00, 8'hFF, 8'hFF);
      send_event(ST_START);
      send_event(ST_SLAW_ACK);
      send_event(ST_DATW_ACK);
      send_event(ST_RSTART);
      send_event(ST_SLAR_ACK);
      send_event(ST_DATR_ACK);
      send_event(ST_DATR_NACK);
      send_event(ST_IDLE);
      send_start(8'h5A, 8'h00, 8'h01);
      send_event(ST_START);
      send_event(ST_SLAR_NACK);
      send_event(ST_IDLE);
      send_start(8'hFF, 8'hFF, 8'hFF);
      send_event(ST_START);
      send_event(ST_ARB_LOST);
      send_event(ST_SLAW_NACK);
      send_event(ST_DATW_NACK);
      send_event(8'h00);
      send_event(8'hFF);
      send_event(ST_IDLE);
      drain_results();

      while (items_sent < ITEM_TARGET) begin
         calm = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 4) == 0) stir_noise();
         else run_transfer();
         if ($urandom_range(0, 11) == 0) drain_results();
      end
      drain_results();
      repeat (4) @(posedge clock);

      if (book.mismatches == 0) begin
         $display("i2c_master_transfer_sequencer_core: match");
      end else begin
         $display("i2c_master_transfer_sequencer_core: mismatch");
      end
      $finish;
   end

endmodule
